// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the pair energy accumulator.
// Depends on nothing; empty bodies when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ===== hw/rtl/mp2pe_pkg.sv =====
// Types, constants and saturation helpers of the MP2 pair energy accumulator.
// Depends on nothing.
package mp2pe_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int THR_W     = 40;
    localparam int DEN_W     = 67;   // signed ei+ej-ea-eb
    localparam int OPA_W     = 66;   // signed 2x-y, x-y or x
    localparam int MAG_W     = 66;   // |D|
    localparam int DIVR_W    = 68;   // |D| or 4|D|
    localparam int PROD_W    = 128;
    localparam int WIDE_W    = 68;   // room for sums of four 64-bit values
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] OP_RESTRICTED  = 2'd0;
    localparam logic [1:0] OP_ALPHA_ALPHA = 2'd1;
    localparam logic [1:0] OP_BETA_BETA   = 2'd2;
    localparam logic [1:0] OP_ALPHA_BETA  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SKIP_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_ENERGY = 2'd1;

    localparam logic [THR_W-1:0] THR_RESET = 40'd281;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [63:0] integral_iajb;
        logic signed [63:0] integral_ibja;
        logic signed [63:0] energy_i;
        logic signed [63:0] energy_j;
        logic signed [63:0] energy_a;
        logic signed [63:0] energy_b;
        logic               last;
    } item_t;

    typedef struct packed {
        logic signed [63:0] sum_restricted;
        logic signed [63:0] sum_alpha_alpha;
        logic signed [63:0] sum_beta_beta;
        logic signed [63:0] sum_alpha_beta;
        logic signed [63:0] correlation_total;
        logic signed [63:0] total_energy;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;   // quotient of 2^64 or more
    } div_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_DEN,
        S_MAG,
        S_TEST,
        S_MUL,
        S_DIV,
        S_ACC,
        S_CORR,
        S_TOTAL
    } state_t;

    function automatic logic [WIDE_W-1:0] sext_wide(input logic [63:0] v);
        return {{(WIDE_W-64){v[63]}}, v};
    endfunction

    function automatic logic fits_s64(input logic [WIDE_W-1:0] v);
        return v[WIDE_W-1:63] == {(WIDE_W-63){v[63]}};
    endfunction

    function automatic logic [63:0] sat_s64(input logic [WIDE_W-1:0] v);
        logic [63:0] r;
        if (fits_s64(v))
        begin
            r = v[63:0];
        end
        else if (v[WIDE_W-1])
        begin
            r = S64_MIN;
        end
        else
        begin
            r = S64_MAX;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mp2pe_mul.sv =====
// Iterative 65 x 64 bit unsigned multiplier built on one 32 x 32 multiplier.
// Depends on mp2pe_pkg.
module mp2pe_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [64:0]                    a,
    input  logic [63:0]                    b,
    output logic                           done,
    output logic [mp2pe_pkg::PROD_W-1:0]   product
);

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_32 = 2'd1;
    localparam logic [1:0] SH_64 = 2'd2;
    localparam logic [2:0] LAST_STEP = 3'd4;

    logic                          busy_reg;
    logic [2:0]                    cnt_reg;
    logic                          pp_valid_reg;
    logic                          done_reg;
    logic [63:0]                   a_reg;
    logic [63:0]                   b_reg;
    logic [63:0]                   pp_reg;
    logic [1:0]                    pp_sh_reg;
    logic [mp2pe_pkg::PROD_W-1:0]  prod_reg;

    logic [31:0]                   a_half;
    logic [31:0]                   b_half;
    logic [1:0]                    sh_sel;
    logic [63:0]                   pp_next;
    logic [mp2pe_pkg::PROD_W-1:0]  pp_shifted;
    logic                          finish;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                a_half = a_reg[31:0];
                b_half = b_reg[31:0];
                sh_sel = SH_0;
            end
            2'd1:
            begin
                a_half = a_reg[31:0];
                b_half = b_reg[63:32];
                sh_sel = SH_32;
            end
            2'd2:
            begin
                a_half = a_reg[63:32];
                b_half = b_reg[31:0];
                sh_sel = SH_32;
            end
            default:
            begin
                a_half = a_reg[63:32];
                b_half = b_reg[63:32];
                sh_sel = SH_64;
            end
        endcase
        pp_next = a_half * b_half;
    end

    always_comb
    begin
        case (pp_sh_reg)
            SH_0:    pp_shifted = {64'd0, pp_reg};
            SH_32:   pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    assign finish  = busy_reg && (cnt_reg == LAST_STEP) && pp_valid_reg;
    assign done    = done_reg;
    assign product = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            pp_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
            if (start)
            begin
                busy_reg     <= 1'b1;
                cnt_reg      <= '0;
                pp_valid_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != LAST_STEP)
                begin
                    cnt_reg      <= cnt_reg + 3'd1;
                    pp_valid_reg <= 1'b1;
                end
                else
                begin
                    pp_valid_reg <= 1'b0;
                    busy_reg     <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a[63:0];
            b_reg    <= b;
            // top bit of a contributes b shifted up by 64
            prod_reg <= a[64] ? {b, 64'd0} : '0;
        end
        else
        begin
            if (busy_reg && cnt_reg != LAST_STEP)
            begin
                pp_reg    <= pp_next;
                pp_sh_reg <= sh_sel;
            end
            if (busy_reg && pp_valid_reg)
            begin
                prod_reg <= prod_reg + pp_shifted;
            end
        end
    end

endmodule

// ===== hw/rtl/mp2pe_div.sv =====
// Radix-2 restoring divider: 128-bit dividend over 68-bit divisor, 64 quotient bits.
// Depends on mp2pe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mp2pe_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mp2pe_pkg::PROD_W-1:0]   num,
    input  logic [mp2pe_pkg::DIVR_W-1:0]   divisor,
    output mp2pe_pkg::div_status_t         status,
    output logic [63:0]                    quot
);

    localparam int RW = mp2pe_pkg::DIVR_W;
    localparam logic [mp2pe_pkg::DIV_CNT_W-1:0] CNT_LAST =
        mp2pe_pkg::DIV_CNT_W'(mp2pe_pkg::DIV_STEPS - 1);

    logic                              busy_reg;
    logic                              done_reg;
    logic                              ovf_reg;
    logic [mp2pe_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [RW-1:0]                     rem_reg;
    logic [RW-1:0]                     divisor_reg;
    logic [63:0]                       q_reg;

    logic [RW-1:0]                     num_hi;
    logic                              start_ovf;
    logic [RW:0]                       r2;
    logic [RW+1:0]                     diff;
    logic                              ge;

    assign num_hi    = {{(RW-64){1'b0}}, num[127:64]};
    assign start_ovf = num_hi >= divisor;

    // subtractor: trial subtract of the shifted remainder
    assign r2   = {rem_reg, q_reg[63]};
    assign diff = {1'b0, r2} - {2'b00, divisor_reg};
    assign ge   = !diff[RW+1];

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign status.ovf  = ovf_reg;
    assign quot        = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                ovf_reg <= start_ovf;
                cnt_reg <= '0;
                if (start_ovf)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= num_hi;
            q_reg       <= num[63:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[RW-1:0] : r2[RW-1:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    `ASSERT_IMPLY(a_rem_below_divisor, clk, rst_n, busy_reg, rem_reg < divisor_reg)
    `ASSERT_IMPLY(a_no_restart, clk, rst_n, start, !busy_reg)
    `ASSERT_IMPLY(a_idle_count_zero, clk, rst_n, !busy_reg, cnt_reg == '0)

endmodule

// ===== hw/rtl/mp2_pair_energy_accumulator_core.sv =====
// MP2 pair energy accumulator, top level.
// Channels: item (valid/ready, mp2pe_pkg::item_t) carries one orbital quadruple;
// result (valid/ready, mp2pe_pkg::result_t) carries the four sums, the
// correlation total, the reference-plus-correlation total and the clip flag.
// cfg_we/cfg_index/cfg_data write skip_threshold (0) and reference_energy (1).
// An item goes from accept through the denominator setup states (S_SUM, S_DEN,
// S_MAG, S_TEST), the 32x32 partial-product multiplier and the radix-2
// divider, which produces one quotient bit per cycle. A term whose |D| is zero
// or under the threshold skips the multiplier and divider; one whose numerator
// is zero skips the divider. item_ready is high only while idle.
// The item marked last adds the S_CORR and S_TOTAL states for the totals; its
// result beat sits in an output register, so the block keeps accepting items
// while the receiver stalls and only waits when a second result is ready
// before the first is taken.
// Reset clears the sums, the clip flag and result_valid, and loads the
// threshold with 281 and the reference energy with zero.
`include "assert_macros.svh"

module mp2_pair_energy_accumulator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  mp2pe_pkg::item_t                    item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output mp2pe_pkg::result_t                  result,
    input  logic                                cfg_we,
    input  logic [mp2pe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                         cfg_data
);

    mp2pe_pkg::state_t                 state_reg;
    mp2pe_pkg::state_t                 state_next;
    mp2pe_pkg::state_t                 tail_state;

    mp2pe_pkg::item_t                  item_reg;
    logic [mp2pe_pkg::DEN_W-1:0]       sij_reg;
    logic [mp2pe_pkg::DEN_W-1:0]       sab_reg;
    logic [mp2pe_pkg::OPA_W-1:0]       opa_reg;
    logic [mp2pe_pkg::DEN_W-1:0]       d_reg;
    logic [64:0]                       amag_reg;
    logic [63:0]                       bmag_reg;
    logic                              nneg_reg;
    logic                              dneg_reg;
    logic [mp2pe_pkg::MAG_W-1:0]       dm_reg;
    logic [mp2pe_pkg::DIVR_W-1:0]      div_reg;
    logic [63:0]                       term_reg;
    logic                              term_clip_reg;
    logic [63:0]                       corr_reg;
    logic                              corr_clip_reg;
    logic [63:0]                       acc_reg [4];
    logic                              clip_reg;
    logic [mp2pe_pkg::THR_W-1:0]       thr_reg;
    logic [63:0]                       ref_reg;
    mp2pe_pkg::result_t                result_reg;
    logic                              result_valid_reg;

    logic                              accept;
    logic                              same_spin;
    logic                              skip;
    logic                              mul_start;
    logic                              mul_done;
    logic [mp2pe_pkg::PROD_W-1:0]      prod;
    logic                              prod_zero;
    logic                              div_start;
    mp2pe_pkg::div_status_t            div_stat;
    logic [63:0]                       quot;
    logic                              result_load;

    logic [mp2pe_pkg::OPA_W-1:0]       x_ext;
    logic [mp2pe_pkg::OPA_W-1:0]       y_ext;
    logic [mp2pe_pkg::OPA_W-1:0]       opa_next;
    logic [mp2pe_pkg::OPA_W-1:0]       opa_abs;
    logic [63:0]                       xmag;
    logic [mp2pe_pkg::DEN_W-1:0]       d_abs;
    logic                              term_neg;
    logic [63:0]                       term_next;
    logic                              term_clip_next;
    logic [mp2pe_pkg::WIDE_W-1:0]      acc_sum;
    logic [mp2pe_pkg::WIDE_W-1:0]      sum4;
    logic [mp2pe_pkg::WIDE_W-1:0]      tot_sum;

    // ---------------------------------------------------------------
    // arithmetic units
    // ---------------------------------------------------------------
    mp2pe_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (amag_reg),
        .b       (bmag_reg),
        .done    (mul_done),
        .product (prod)
    );

    mp2pe_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (prod),
        .divisor (div_reg),
        .status  (div_stat),
        .quot    (quot)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign accept     = item_valid && item_ready;
    assign same_spin  = item_reg.op inside {mp2pe_pkg::OP_ALPHA_ALPHA, mp2pe_pkg::OP_BETA_BETA};
    assign skip       = (dm_reg == '0) ||
                        (dm_reg < {{(mp2pe_pkg::MAG_W-mp2pe_pkg::THR_W){1'b0}}, thr_reg});
    assign prod_zero  = (prod == '0);
    assign tail_state = item_reg.last ? mp2pe_pkg::S_CORR : mp2pe_pkg::S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mp2pe_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = mp2pe_pkg::S_SUM;
                end
            end
            mp2pe_pkg::S_SUM:  state_next = mp2pe_pkg::S_DEN;
            mp2pe_pkg::S_DEN:  state_next = mp2pe_pkg::S_MAG;
            mp2pe_pkg::S_MAG:  state_next = mp2pe_pkg::S_TEST;
            mp2pe_pkg::S_TEST: state_next = skip ? tail_state : mp2pe_pkg::S_MUL;
            mp2pe_pkg::S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = prod_zero ? tail_state : mp2pe_pkg::S_DIV;
                end
            end
            mp2pe_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = mp2pe_pkg::S_ACC;
                end
            end
            mp2pe_pkg::S_ACC:  state_next = tail_state;
            mp2pe_pkg::S_CORR: state_next = mp2pe_pkg::S_TOTAL;
            mp2pe_pkg::S_TOTAL:
            begin
                if (result_load)
                begin
                    state_next = mp2pe_pkg::S_IDLE;
                end
            end
            default: state_next = mp2pe_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready  = (state_reg == mp2pe_pkg::S_IDLE);
        mul_start   = (state_reg == mp2pe_pkg::S_TEST) && !skip;
        div_start   = (state_reg == mp2pe_pkg::S_MUL) && mul_done && !prod_zero;
        result_load = (state_reg == mp2pe_pkg::S_TOTAL) && (!result_valid_reg || result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mp2pe_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // operand preparation
    // ---------------------------------------------------------------
    assign x_ext = {{2{item_reg.integral_iajb[63]}}, item_reg.integral_iajb};
    assign y_ext = {{2{item_reg.integral_ibja[63]}}, item_reg.integral_ibja};

    always_comb
    begin
        case (item_reg.op)
            mp2pe_pkg::OP_RESTRICTED: opa_next = {x_ext[mp2pe_pkg::OPA_W-2:0], 1'b0} - y_ext;
            mp2pe_pkg::OP_ALPHA_BETA: opa_next = x_ext;
            default:                  opa_next = x_ext - y_ext;
        endcase
    end

    assign opa_abs = opa_reg[mp2pe_pkg::OPA_W-1] ? ('0 - opa_reg) : opa_reg;
    assign xmag    = item_reg.integral_iajb[63] ? (64'd0 - item_reg.integral_iajb)
                                                : item_reg.integral_iajb;
    assign d_abs   = d_reg[mp2pe_pkg::DEN_W-1] ? ('0 - d_reg) : d_reg;

    // signed term from the quotient magnitude
    assign term_neg = nneg_reg ^ dneg_reg;

    always_comb
    begin
        term_clip_next = 1'b0;
        if (div_stat.ovf)
        begin
            term_clip_next = 1'b1;
            term_next      = term_neg ? mp2pe_pkg::S64_MIN : mp2pe_pkg::S64_MAX;
        end
        else if (!term_neg)
        begin
            term_clip_next = quot[63];
            term_next      = quot[63] ? mp2pe_pkg::S64_MAX : quot;
        end
        else if (quot[63] && (quot[62:0] != '0))
        begin
            term_clip_next = 1'b1;
            term_next      = mp2pe_pkg::S64_MIN;
        end
        else
        begin
            term_next = 64'd0 - quot;
        end
    end

    assign acc_sum = mp2pe_pkg::sext_wide(acc_reg[item_reg.op])
                   + mp2pe_pkg::sext_wide(term_reg);
    assign sum4    = (mp2pe_pkg::sext_wide(acc_reg[0]) + mp2pe_pkg::sext_wide(acc_reg[1]))
                   + (mp2pe_pkg::sext_wide(acc_reg[2]) + mp2pe_pkg::sext_wide(acc_reg[3]));
    assign tot_sum = mp2pe_pkg::sext_wide(ref_reg) + mp2pe_pkg::sext_wide(corr_reg);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mp2pe_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_reg <= item;
                end
            end
            mp2pe_pkg::S_SUM:
            begin
                sij_reg <= {{3{item_reg.energy_i[63]}}, item_reg.energy_i}
                         + {{3{item_reg.energy_j[63]}}, item_reg.energy_j};
                sab_reg <= {{3{item_reg.energy_a[63]}}, item_reg.energy_a}
                         + {{3{item_reg.energy_b[63]}}, item_reg.energy_b};
                opa_reg <= opa_next;
            end
            mp2pe_pkg::S_DEN:
            begin
                d_reg    <= sij_reg - sab_reg;
                amag_reg <= opa_abs[64:0];
                bmag_reg <= same_spin ? opa_abs[63:0] : xmag;
                nneg_reg <= (item_reg.op == mp2pe_pkg::OP_RESTRICTED) &&
                            (item_reg.integral_iajb[63] != opa_reg[mp2pe_pkg::OPA_W-1]);
            end
            mp2pe_pkg::S_MAG:
            begin
                dm_reg   <= d_abs[mp2pe_pkg::MAG_W-1:0];
                dneg_reg <= d_reg[mp2pe_pkg::DEN_W-1];
            end
            mp2pe_pkg::S_TEST:
            begin
                // same-spin terms carry the factor 0.25 in the divisor
                div_reg <= same_spin ? {dm_reg, 2'b00} : {2'b00, dm_reg};
            end
            mp2pe_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    term_reg      <= term_next;
                    term_clip_reg <= term_clip_next;
                end
            end
            mp2pe_pkg::S_CORR:
            begin
                corr_reg      <= mp2pe_pkg::sat_s64(sum4);
                corr_clip_reg <= !mp2pe_pkg::fits_s64(sum4);
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // accumulators
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
            acc_reg[3] <= '0;
            clip_reg   <= 1'b0;
        end
        else if (result_load)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
            acc_reg[3] <= '0;
            clip_reg   <= 1'b0;
        end
        else if (state_reg == mp2pe_pkg::S_ACC)
        begin
            acc_reg[item_reg.op] <= mp2pe_pkg::sat_s64(acc_sum);
            clip_reg <= clip_reg || term_clip_reg || !mp2pe_pkg::fits_s64(acc_sum);
        end
    end

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= mp2pe_pkg::THR_RESET;
            ref_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mp2pe_pkg::REG_SKIP_THRESHOLD:   thr_reg <= cfg_data[mp2pe_pkg::THR_W-1:0];
                mp2pe_pkg::REG_REFERENCE_ENERGY: ref_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg.sum_restricted    <= acc_reg[mp2pe_pkg::OP_RESTRICTED];
            result_reg.sum_alpha_alpha   <= acc_reg[mp2pe_pkg::OP_ALPHA_ALPHA];
            result_reg.sum_beta_beta     <= acc_reg[mp2pe_pkg::OP_BETA_BETA];
            result_reg.sum_alpha_beta    <= acc_reg[mp2pe_pkg::OP_ALPHA_BETA];
            result_reg.correlation_total <= corr_reg;
            result_reg.total_energy      <= mp2pe_pkg::sat_s64(tot_sum);
            result_reg.saturated         <= clip_reg || corr_clip_reg ||
                                            !mp2pe_pkg::fits_s64(tot_sum);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !item_ready)
    `ASSERT_NEXT(a_clear_after_emit, clk, rst_n, result_load, (acc_reg[0] == '0) && (acc_reg[1] == '0) && (acc_reg[2] == '0) && (acc_reg[3] == '0) && !clip_reg)
    `ASSERT_IMPLY(a_idle_divider_quiet, clk, rst_n, state_reg == mp2pe_pkg::S_IDLE, !div_stat.busy)

endmodule
